/* hdl/min_priority_queue_decrease_key_top_defines.svh */
// Assertion macros for the decrease-key priority queue.
// Depends on nothing; included by the top level only.
`ifndef MIN_PRIORITY_QUEUE_DECREASE_KEY_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DECREASE_KEY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQDK_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("mpqdk: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPQDK_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("mpqdk: next-cycle check failed");

`endif

/* hdl/mpqdk_pkg.sv */
// Shared types and constants of the decrease-key priority queue.
// No dependencies; imported by the engine and the top level.
package mpqdk_pkg;

  localparam int CAPACITY   = 256;
  localparam int COORD_BITS = 10;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TIME_W   = 32;
  localparam int COORD_W  = 10;
  localparam int REM_W    = 9;
  localparam int KEY_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int KEY_W    = 3 * KEY_BITS;
  localparam int ENTRY_W  = TIME_W + KEY_W;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELMIN = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [TIME_W-1:0]  travel_time;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [TIME_W-1:0]  min_time;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [REM_W-1:0]   remaining;
  } out_item_t;

  // One stored entry: time above packed z, y, x coordinates.
  typedef struct packed {
    logic [TIME_W-1:0] tval;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

/* hdl/mpqdk_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpqdk_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mpqdk_engine.sv */
// Queue engine: one-hot sequencer that scans and compacts the entry RAM.
// Depends on mpqdk_pkg; drives the RAM request struct.
module mpqdk_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpqdk_pkg::in_item_t  in_data,
  output logic                 res_valid,
  input  logic                 res_take,
  output mpqdk_pkg::out_item_t res_data,
  output mpqdk_pkg::ram_req_t  ram_req,
  input  mpqdk_pkg::entry_t    ram_rdata
);
  import mpqdk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  op_t               op_r, op_nxt;
  logic [TIME_W-1:0] tt_r, tt_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              issue_r, issue_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              best_v_r, best_v_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  entry_t            best_r, best_nxt;
  status_t           status_r, status_nxt;

  logic [IDX_W-1:0]  last_idx;
  logic [KEY_W-1:0]  in_key;
  logic              take;
  logic [IDX_W-1:0]  cand_idx;
  logic              show_min;

  assign last_idx = IDX_W'(count_r - 1'b1);
  assign in_key   = {in_data.coord_z[KEY_BITS-1:0], in_data.coord_y[KEY_BITS-1:0],
                     in_data.coord_x[KEY_BITS-1:0]};
  // Strict less-than: on a tie the newer entry, seen first, stays best.
  assign take     = !best_v_r || (ram_rdata.tval < best_r.tval);
  assign cand_idx = take ? chk_idx_r : best_idx_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    op_nxt       = op_r;
    tt_nxt       = tt_r;
    key_nxt      = key_r;
    issue_nxt    = issue_r;
    rd_idx_nxt   = rd_idx_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    best_v_nxt   = best_v_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    status_nxt   = status_r;
    ram_req      = '0;
    in_ready     = (state_r == S_IDLE);
    res_valid    = (state_r == S_RESP);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          tt_nxt     = in_data.travel_time;
          key_nxt    = in_key;
          best_v_nxt = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          case (in_data.operation)
            OP_PUSH: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_req.we         = 1'b1;
                ram_req.waddr      = count_r[IDX_W-1:0];
                ram_req.wdata.tval = in_data.travel_time;
                ram_req.wdata.key  = in_key;
                count_nxt          = count_r + 1'b1;
              end
            end
            OP_UPDATE, OP_DELMIN: begin
              if (count_r == '0) begin
                status_nxt = (in_data.operation == OP_UPDATE) ? ST_NOT_FOUND : ST_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                issue_nxt  = 1'b1;
                chk_v_nxt  = 1'b0;
                rd_idx_nxt = last_idx;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Walk from newest to oldest; read data returns in the cycle after the read.
        ram_req.re    = issue_r;
        ram_req.raddr = rd_idx_r;
        chk_v_nxt     = issue_r;
        chk_idx_nxt   = rd_idx_r;
        if (issue_r) begin
          if (rd_idx_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
        if (chk_v_r) begin
          if (op_r == OP_UPDATE) begin
            if (ram_rdata.key == key_r) begin
              ram_req.we         = 1'b1;
              ram_req.waddr      = chk_idx_r;
              ram_req.wdata.tval = tt_r;
              ram_req.wdata.key  = ram_rdata.key;
              issue_nxt          = 1'b0;
              chk_v_nxt          = 1'b0;
              state_nxt          = S_RESP;
            end else if (chk_idx_r == '0) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_RESP;
            end
          end else begin
            if (take) begin
              best_v_nxt   = 1'b1;
              best_idx_nxt = chk_idx_r;
              best_nxt     = ram_rdata;
            end
            if (chk_idx_r == '0) begin
              if (cand_idx == last_idx) begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_RESP;
              end else begin
                state_nxt  = S_SHIFT;
                issue_nxt  = 1'b1;
                rd_idx_nxt = cand_idx + 1'b1;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        // Close the gap: copy entry i down to i-1, oldest side first.
        ram_req.re    = issue_r;
        ram_req.raddr = rd_idx_r;
        chk_v_nxt     = issue_r;
        chk_idx_nxt   = rd_idx_r;
        if (issue_r) begin
          if (rd_idx_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (chk_v_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = chk_idx_r - 1'b1;
          ram_req.wdata = ram_rdata;
          if (chk_idx_r == last_idx) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign show_min = (op_r == OP_DELMIN) && (status_r == ST_OK);

  always_comb begin
    res_data.status    = status_r;
    res_data.min_time  = show_min ? best_r.tval : '0;
    res_data.min_x     = show_min ? COORD_W'(best_r.key[KEY_BITS-1:0]) : '0;
    res_data.min_y     = show_min ? COORD_W'(best_r.key[2*KEY_BITS-1:KEY_BITS]) : '0;
    res_data.min_z     = show_min ? COORD_W'(best_r.key[3*KEY_BITS-1:2*KEY_BITS]) : '0;
    res_data.remaining = REM_W'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      issue_r  <= 1'b0;
      chk_v_r  <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      issue_r  <= issue_nxt;
      chk_v_r  <= chk_v_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tt_r       <= tt_nxt;
    key_r      <= key_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    status_r   <= status_nxt;
  end

endmodule

/* hdl/min_priority_queue_decrease_key_top.sv */
// Top level of the decrease-key priority queue: engine, entry RAM, result register.
// Depends on mpqdk_pkg, mpqdk_ram, mpqdk_engine and the assertion macro header.
//
//   Channel   Handshake              Payload     Direction
//   --------  ---------------------  ----------  ---------
//   input     in_valid / in_ready    in_data     in
//   result    out_valid / out_ready  out_data    out
//
// One beat at a time. Push and no-op go straight to a ready result.
// Update reads held entries newest first, one a cycle, and stops at the first
// match. Delete-min reads all held entries, then copies the entries above the
// winner down by one. The entry RAM has a single read port.
// Reset clears the count, the sequencer and the output valid flag only; no RAM clearing pass.
// A waiting result does not block the next input beat; a second finished
// result holds in the engine until the output register frees up.
`include "min_priority_queue_decrease_key_top_defines.svh"

module min_priority_queue_decrease_key_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpqdk_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpqdk_pkg::out_item_t out_data
);
  import mpqdk_pkg::*;

  ram_req_t  ram_req;
  entry_t    ram_rdata;
  logic      res_valid;
  logic      res_take;
  out_item_t res_data;

  logic      out_valid_r;
  out_item_t out_data_r;

  // Load the result register when it is empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  mpqdk_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Entries stay compact in age order: address 0 is the oldest held entry.
  mpqdk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: hold until taken, drop valid once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Scan and compaction never read the entry being written in the same cycle.
  `MPQDK_ASSERT_IMP(a_ram_no_collide, clk, rst_n, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr)
  // Only one beat is in work at a time.
  `MPQDK_ASSERT_NXT(a_one_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  // A handed-over result always lands in the output register.
  `MPQDK_ASSERT_NXT(a_result_lands, clk, rst_n, res_take, out_valid)
  // The reported count never exceeds the capacity.
  `MPQDK_ASSERT_IMP(a_rem_bound, clk, rst_n, out_valid, out_data.remaining <= REM_W'(CAPACITY))

endmodule
